// ===== hdl/ppch_pkg.sv =====
// Package: sizes, request codes and formats shared by the pair-count histogram.
`timescale 1ns / 1ps
`default_nettype none
package ppch_pkg;

  // Histogram size and derived address widths
  localparam int NumBins   = 16;
  localparam int EdgeDepth = NumBins + 1;
  localparam int EdgeAw    = $clog2(EdgeDepth);
  localparam int BinAw     = (NumBins > 1) ? $clog2(NumBins) : 1;

  // Field widths
  localparam int CoordW  = 32;
  localparam int DistW   = 24;
  localparam int WeightW = 24;
  localparam int SlotW   = 7;
  localparam int EdgeW   = 48;
  localparam int SumW    = 56;
  localparam int BinNumW = 6;

  // Request codes
  localparam logic [1:0] ReqPair = 2'd0;
  localparam logic [1:0] ReqEdge = 2'd1;
  localparam logic [1:0] ReqDump = 2'd2;

endpackage
`default_nettype wire

// ===== hdl/projected_pair_count_histogram.sv =====
// Top level: weighted pair-count histogram with squared-edge binning.
//
// One input channel (in_valid_i / in_stall_o) carries three kinds of
// transaction selected by req_type_i: a pair to accumulate, a squared bin
// edge to load, or a dump of all bin sums. The output channel
// (out_valid_o / out_stall_i) returns one transaction per bin on a dump,
// bins in ascending order, last_bin_o marking the final one.
// Items are processed one at a time; in_stall_o is high while one is busy.
// - Edge load: written while idle, so the next item is accepted the cycle after.
// - Pair: steps through the one shared 35x35 multiplier (distance squared,
//   three dot-product terms, two partial products of the separation), then
//   walks the edge RAM entries 0 to NumBins, then does a read-modify-write
//   of the sum RAM. A discarded pair returns to idle early.
// - Dump: each bin steps through StDrd, StDld and StDwait, paced by the sum
//   RAM read and the receiver; each bin is cleared as it is read out.
// A stall on the output holds the current result; no further bin is read
// until it is taken. Reset clears all bin sums at once (per-bin valid
// bits); the edge table holds no value until it is loaded.
`timescale 1ns / 1ps
`default_nettype none
module projected_pair_count_histogram (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    req_type_i,
  input  logic signed [ppch_pkg::CoordW-1:0] prim_x_i,
  input  logic signed [ppch_pkg::CoordW-1:0] prim_y_i,
  input  logic signed [ppch_pkg::CoordW-1:0] prim_z_i,
  input  logic [ppch_pkg::DistW-1:0]    prim_distance_i,
  input  logic [ppch_pkg::WeightW-1:0]  prim_weight_i,
  input  logic signed [ppch_pkg::CoordW-1:0] sec_x_i,
  input  logic signed [ppch_pkg::CoordW-1:0] sec_y_i,
  input  logic signed [ppch_pkg::CoordW-1:0] sec_z_i,
  input  logic [ppch_pkg::SlotW-1:0]    edge_slot_i,
  input  logic [ppch_pkg::EdgeW-1:0]    edge_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ppch_pkg::BinNumW-1:0]  bin_number_o,
  output logic [ppch_pkg::SumW-1:0]     bin_total_o,
  output logic                          last_bin_o
);
  import ppch_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StMul, StSrch, StWsum, StDrd, StDld, StDwait
  } state_e;

  state_e state_q;
  logic [3:0] mstep_q;

  // Captured pair operands
  logic signed [CoordW-1:0] px_q, py_q, pz_q, sx_q, sy_q, sz_q;
  logic [DistW-1:0]   dist_q;
  logic [WeightW-1:0] weight_q;

  // Arithmetic registers
  logic signed [69:0] prod_q;
  logic signed [63:0] dot_q;
  logic [2*DistW-1:0] d2_q;
  logic [81:0]        acc_q;
  logic [EdgeW-1:0]   rp2_q;

  // Search and dump counters
  logic [EdgeAw-1:0] kk_q;
  logic [BinAw-1:0]  bin_q;
  logic [BinAw-1:0]  dk_q;

  // Output registers
  logic               out_valid_q;
  logic [SumW-1:0]    out_total_q;
  logic [BinNumW-1:0] out_num_q;
  logic               out_last_q;

  // Sum valid bits
  logic [NumBins-1:0] sum_vld_q;
  logic               vld_rd_q;

  logic in_acc, out_acc;
  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  // Shared multiplier operand select
  logic signed [34:0] mul_a, mul_b;
  logic signed [63:0] om;
  logic [33:0]        om30;
  assign om   = {6'b000001, 58'b0} - dot_q;
  assign om30 = om[61:28];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mstep_q)
      4'd0: begin
        mul_a = {11'b0, dist_q};
        mul_b = {11'b0, dist_q};
      end
      4'd1: begin
        mul_a = {{3{px_q[CoordW-1]}}, px_q};
        mul_b = {{3{sx_q[CoordW-1]}}, sx_q};
      end
      4'd2: begin
        mul_a = {{3{py_q[CoordW-1]}}, py_q};
        mul_b = {{3{sy_q[CoordW-1]}}, sy_q};
      end
      4'd3: begin
        mul_a = {{3{pz_q[CoordW-1]}}, pz_q};
        mul_b = {{3{sz_q[CoordW-1]}}, sz_q};
      end
      4'd5: begin
        mul_a = {11'b0, d2_q[23:0]};
        mul_b = {1'b0, om30};
      end
      4'd6: begin
        mul_a = {11'b0, d2_q[47:24]};
        mul_b = {1'b0, om30};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic signed [69:0] prod_d;
  assign prod_d = mul_a * mul_b;

  // Saturated separation
  logic [EdgeW-1:0] rp2_d;
  assign rp2_d = (acc_q[81:77] != 5'b0) ? {EdgeW{1'b1}} : acc_q[76:29];

  // Edge RAM ports
  logic              edge_we;
  logic [EdgeAw-1:0] edge_raddr;
  logic [EdgeW-1:0]  edge_rd;
  assign edge_we    = in_acc && (req_type_i == ReqEdge) &&
                      (edge_slot_i <= SlotW'(NumBins));
  assign edge_raddr = (state_q == StSrch) ? EdgeAw'(kk_q + 1'b1) : '0;

  ppch_ram #(.Width(EdgeW), .Depth(EdgeDepth)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_slot_i[EdgeAw-1:0]),
    .wdata_i (edge_value_i),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rd)
  );

  // Sum RAM ports
  logic             sum_we;
  logic [BinAw-1:0] sum_waddr, sum_raddr;
  logic [SumW-1:0]  sum_wdata, sum_rd, sum_cur;
  logic [SumW:0]    sum_add;
  assign sum_raddr = (state_q == StSrch) ? bin_q : dk_q;
  assign sum_cur   = vld_rd_q ? sum_rd : '0;
  assign sum_add   = {1'b0, sum_cur} + (SumW + 1)'(weight_q);

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = bin_q;
    sum_wdata = '0;
    if (state_q == StWsum) begin
      sum_we    = 1'b1;
      sum_wdata = sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];
    end else if (state_q == StDld) begin
      sum_we    = 1'b1;
      sum_waddr = dk_q;
    end
  end

  ppch_ram #(.Width(SumW), .Depth(NumBins)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rd)
  );

  // Sequencer: state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mstep_q     <= '0;
      px_q <= '0; py_q <= '0; pz_q <= '0;
      sx_q <= '0; sy_q <= '0; sz_q <= '0;
      dist_q      <= '0;
      weight_q    <= '0;
      prod_q      <= '0;
      dot_q       <= '0;
      d2_q        <= '0;
      acc_q       <= '0;
      rp2_q       <= '0;
      kk_q        <= '0;
      bin_q       <= '0;
      dk_q        <= '0;
      out_valid_q <= 1'b0;
      out_total_q <= '0;
      out_num_q   <= '0;
      out_last_q  <= 1'b0;
      sum_vld_q   <= '0;
      vld_rd_q    <= 1'b0;
    end else begin
      prod_q   <= prod_d;
      vld_rd_q <= sum_vld_q[sum_raddr];
      if (sum_we) begin
        sum_vld_q[sum_waddr] <= 1'b1;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            px_q <= prim_x_i; py_q <= prim_y_i; pz_q <= prim_z_i;
            sx_q <= sec_x_i;  sy_q <= sec_y_i;  sz_q <= sec_z_i;
            dist_q   <= prim_distance_i;
            weight_q <= prim_weight_i;
            mstep_q  <= '0;
            dk_q     <= '0;
            if (req_type_i == ReqPair) begin
              state_q <= StMul;
            end else if (req_type_i == ReqDump) begin
              state_q <= StDrd;
            end
          end
        end
        StMul: begin
          // Consume the product of the previous step
          mstep_q <= mstep_q + 4'd1;
          case (mstep_q)
            4'd1: d2_q  <= prod_q[47:0];
            4'd2: dot_q <= 64'(prod_q >>> 2);
            4'd3: dot_q <= dot_q + 64'(prod_q >>> 2);
            4'd4: dot_q <= dot_q + 64'(prod_q >>> 2);
            4'd6: acc_q <= 82'(prod_q[57:0]);
            4'd7: acc_q <= acc_q + {prod_q[57:0], 24'b0};
            4'd8: begin
              if (om[63]) begin
                state_q <= StIdle;
              end else begin
                rp2_q   <= rp2_d;
                kk_q    <= '0;
                state_q <= StSrch;
              end
            end
            default: ;
          endcase
        end
        StSrch: begin
          // Walk the edge table, one entry per cycle
          kk_q <= kk_q + 1'b1;
          if (kk_q == '0) begin
            bin_q <= '0;
            if (edge_rd > rp2_q) begin
              state_q <= StIdle;
            end
          end else if (kk_q == EdgeAw'(NumBins)) begin
            if (rp2_q >= edge_rd) begin
              state_q <= StIdle;
            end else begin
              state_q <= StWsum;
            end
          end else if (edge_rd <= rp2_q) begin
            bin_q <= BinAw'(kk_q);
          end
        end
        StWsum: begin
          state_q <= StIdle;
        end
        StDrd: begin
          state_q <= StDld;
        end
        StDld: begin
          out_valid_q <= 1'b1;
          out_total_q <= sum_cur;
          out_num_q   <= BinNumW'(dk_q);
          out_last_q  <= (dk_q == BinAw'(NumBins - 1));
          state_q     <= StDwait;
        end
        StDwait: begin
          if (out_acc) begin
            out_valid_q <= 1'b0;
            if (dk_q == BinAw'(NumBins - 1)) begin
              state_q <= StIdle;
            end else begin
              dk_q    <= dk_q + 1'b1;
              state_q <= StDrd;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign bin_number_o = out_num_q;
  assign bin_total_o  = out_total_q;
  assign last_bin_o   = out_last_q;

endmodule
`default_nettype wire

// ===== hdl/ppch_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module ppch_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench: directed and random traffic against a pair-count histogram with a built-in predictor.
`timescale 1ns / 1ps
module tb;
  import ppch_pkg::*;

  localparam int        CycleLimit = 400000;
  localparam logic [EdgeW-1:0] EdgeMax = {EdgeW{1'b1}};
  localparam logic [SumW-1:0]  SumMax  = {SumW{1'b1}};
  localparam logic [1:0] ReqNone = 2'd3;

  typedef struct {
    logic [1:0]                req;
    logic signed [CoordW-1:0]  px, py, pz;
    logic [DistW-1:0]          distance;
    logic [WeightW-1:0]        wt;
    logic signed [CoordW-1:0]  sx, sy, sz;
    logic [SlotW-1:0]          slot;
    logic [EdgeW-1:0]          val;
  } request_t;

  typedef struct {
    logic [BinNumW-1:0] bin;
    logic [SumW-1:0]    total;
    logic               last;
  } bin_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] req_type_i = ReqPair;
  logic signed [CoordW-1:0] prim_x_i = '0, prim_y_i = '0, prim_z_i = '0;
  logic [DistW-1:0] prim_distance_i = '0;
  logic [WeightW-1:0] prim_weight_i = '0;
  logic signed [CoordW-1:0] sec_x_i = '0, sec_y_i = '0, sec_z_i = '0;
  logic [SlotW-1:0] edge_slot_i = '0;
  logic [EdgeW-1:0] edge_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [BinNumW-1:0] bin_number_o;
  logic [SumW-1:0] bin_total_o;
  logic last_bin_o;

  projected_pair_count_histogram uut (.*);

  // Predictor state
  logic [EdgeW-1:0] edge_copy[EdgeDepth];
  logic [SumW-1:0]  sum_copy[NumBins];
  bin_report_t      pending_bins[$];

  int  errors = 0;
  int  cycles = 0;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;
  int  long_hold = 0;
  int  recv_burst = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Squared projected separation; returns 0 when the pair is discarded
  function automatic bit separation_sq(request_t r, output logic [EdgeW-1:0] rp2);
    longint dot, om;
    logic [47:0] d2;
    logic [127:0] prod, shifted;
    dot = ((longint'(r.px) * longint'(r.sx)) >>> 2) + ((longint'(r.py) * longint'(r.sy)) >>> 2)
        + ((longint'(r.pz) * longint'(r.sz)) >>> 2);
    om = (longint'(1) <<< 58) - dot;
    rp2 = '0;
    if (om < 0) return 1'b0;
    d2 = 48'(r.distance) * 48'(r.distance);
    prod = 128'(d2) * 128'(om >> 28);
    shifted = prod >> 29;
    rp2 = (shifted > 128'(EdgeMax)) ? EdgeMax : shifted[EdgeW-1:0];
    return 1'b1;
  endfunction

  // Advance the predictor by one accepted transaction
  function automatic void histogram_update(request_t r);
    logic [EdgeW-1:0] rp2;
    logic [SumW:0] acc;
    int bin;
    case (r.req)
      ReqPair: begin
        if (separation_sq(r, rp2) && rp2 >= edge_copy[0] && rp2 < edge_copy[NumBins]) begin
          bin = 0;
          for (int k = 1; k < NumBins; k++) if (edge_copy[k] <= rp2) bin = k;
          acc = sum_copy[bin] + r.wt;
          sum_copy[bin] = (acc > SumMax) ? SumMax : acc[SumW-1:0];
        end
      end
      ReqEdge: if (r.slot <= NumBins) edge_copy[r.slot] = r.val;
      ReqDump: begin
        for (int k = 0; k < NumBins; k++) begin
          pending_bins.push_back('{BinNumW'(k), sum_copy[k], k == NumBins - 1});
          sum_copy[k] = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one transaction, hold it until taken
  task automatic send_request(request_t r);
    if (send_idle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= r.req;
    prim_x_i <= r.px; prim_y_i <= r.py; prim_z_i <= r.pz;
    prim_distance_i <= r.distance; prim_weight_i <= r.wt;
    sec_x_i <= r.sx; sec_y_i <= r.sy; sec_z_i <= r.sz;
    edge_slot_i <= r.slot; edge_value_i <= r.val;
    do @(posedge clk_i); while (in_stall_o);
    histogram_update(r);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic signed [CoordW-1:0] rand_coord();
    return CoordW'(longint'($urandom_range(32'h8000_0000, 0)) - (longint'(1) << 30));
  endfunction

  function automatic logic signed [CoordW-1:0] nudge(logic signed [CoordW-1:0] c);
    longint v, span;
    span = longint'(1) << $urandom_range(4, 29);
    v = longint'(c) + longint'($urandom_range(0, 32'hFFFF_FFFF)) % (2 * span) - span;
    if (v > (longint'(1) << 30)) v = longint'(1) << 30;
    if (v < -(longint'(1) << 30)) v = -(longint'(1) << 30);
    return CoordW'(v);
  endfunction

  function automatic request_t edge_req(int slot, logic [EdgeW-1:0] val);
    request_t r = '{default: '0};
    r.req = ReqEdge; r.slot = SlotW'(slot); r.val = val;
    return r;
  endfunction

  function automatic request_t dump_req();
    request_t r = '{default: '0};
    r.req = ReqDump;
    return r;
  endfunction

  // Random pair; mostly near-neighbors so that separations land in the table
  function automatic request_t pair_req();
    request_t r;
    r.req = ReqPair;
    r.px = rand_coord(); r.py = rand_coord(); r.pz = rand_coord();
    if ($urandom_range(0, 3) != 0) begin
      r.sx = nudge(r.px); r.sy = nudge(r.py); r.sz = nudge(r.pz);
    end else begin
      r.sx = rand_coord(); r.sy = rand_coord(); r.sz = rand_coord();
    end
    r.distance = DistW'($urandom) & ((DistW'(1) << $urandom_range(1, DistW)) - 1);
    r.wt = WeightW'($urandom);
    r.slot = SlotW'($urandom);
    r.val = EdgeW'({$urandom, $urandom});
    return r;
  endfunction

  // Load a geometric, non-decreasing table at a random scale
  task automatic load_geometric_table();
    logic [127:0] e;
    logic [EdgeW-1:0] base;
    int step;
    base = EdgeW'($urandom_range(1, 1 << 20));
    step = $urandom_range(1, 2);
    for (int k = 0; k <= NumBins; k++) begin
      e = 128'(base) << (step * k);
      send_request(edge_req(k, (e > 128'(EdgeMax)) ? EdgeMax : e[EdgeW-1:0]));
    end
  endtask

  // Check every result arriving in order against the predicted ones
  always @(posedge clk_i) begin
    bin_report_t exp_bin;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bins.size() == 0) begin
        $error("unexpected bin report: bin %0d total %0h", bin_number_o, bin_total_o);
        errors++;
      end else begin
        exp_bin = pending_bins.pop_front();
        if (bin_number_o !== exp_bin.bin) begin
          $error("bin_number expected %0d actual %0d", exp_bin.bin, bin_number_o);
          errors++;
        end
        if (bin_total_o !== exp_bin.total) begin
          $error("bin_total expected %0h actual %0h", exp_bin.total, bin_total_o);
          errors++;
        end
        if (last_bin_o !== exp_bin.last) begin
          $error("last_bin expected %0b actual %0b", exp_bin.last, last_bin_o);
          errors++;
        end
      end
    end
  end

  // Receiver stall: long hold when asked, else random bursts
  always @(posedge clk_i) begin
    if (long_hold > 0) begin
      out_stall_i <= 1'b1;
      long_hold--;
    end else if (recv_burst > 0) begin
      out_stall_i <= 1'b1;
      recv_burst--;
    end else if (recv_idle && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      recv_burst = $urandom_range(0, 12);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic test_table_load();
    request_t r;
    send_request(dump_req());
    load_geometric_table();
    send_request(edge_req(NumBins + 1, EdgeMax));
    send_request(edge_req(7'h7F, '0));
    r = pair_req();
    r.req = ReqNone;
    send_request(r);
  endtask

  task automatic test_directed_pairs();
    request_t r;
    logic [EdgeW-1:0] rp2;
    r = '{default: '0};
    r.req = ReqPair;
    // identical vectors: zero separation
    r.px = 32'sd1 <<< 30; r.sx = r.px; r.distance = '1; r.wt = '1;
    send_request(r);
    // opposite vectors at full distance and weight
    r.sx = -(32'sd1 <<< 30);
    send_request(r);
    // vectors longer than unit: negative one-minus-cosine
    r.py = 32'sd1 <<< 30; r.sy = r.py; r.sx = r.px;
    send_request(r);
    r.py = '0; r.sy = '0;
    // most negative coordinates, zero weight
    r.px = -(32'sd1 <<< 30); r.pz = -(32'sd1 <<< 30); r.sx = '0; r.sz = '0; r.wt = '0;
    r.distance = 24'd300;
    send_request(r);
    // separation exactly on an edge
    r = pair_req();
    r.distance = 24'h001000;
    if (separation_sq(r, rp2)) begin
      send_request(edge_req(5, rp2));
      send_request(r);
    end
    send_request(dump_req());
    load_geometric_table();
  endtask

  task automatic test_random_table();
    for (int k = 0; k <= NumBins; k++) send_request(edge_req(k, EdgeW'({$urandom, $urandom})));
    repeat (20) send_request(pair_req());
    send_request(dump_req());
  endtask

  task automatic test_output_hold();
    load_geometric_table();
    repeat (5) send_request(pair_req());
    long_hold = 300;
    send_request(dump_req());
    repeat (6) send_request(pair_req());
    send_request(dump_req());
  endtask

  task automatic test_drain_pause();
    repeat (8) send_request(pair_req());
    send_request(dump_req());
    wait_drained();
    send_request(dump_req());
  endtask

  task automatic test_random_mix(int n);
    request_t r;
    for (int i = 0; i < n; i++) begin
      if (i == n - 50) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end
      case ($urandom_range(0, 19))
        0: load_geometric_table();
        1: send_request(dump_req());
        2: begin
          r = pair_req();
          r.req = ReqNone;
          send_request(r);
        end
        3: send_request(edge_req($urandom_range(0, 127), EdgeW'({$urandom, $urandom})));
        default: send_request(pair_req());
      endcase
      if (i % 25 == 24) send_request(dump_req());
    end
    send_request(dump_req());
  endtask

  initial begin
    foreach (sum_copy[k]) sum_copy[k] = '0;
    foreach (edge_copy[k]) edge_copy[k] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_load();
    test_directed_pairs();
    test_random_table();
    test_output_hold();
    test_drain_pause();
    load_geometric_table();
    test_random_mix(90);
    in_valid_i <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ppch_pkg.sv
hdl/ppch_ram.sv
hdl/projected_pair_count_histogram.sv
tb/sv/tb.sv
